### rtl/core/idba_pkg.sv
// ----------------------------------------------------------------------------
// idba_pkg - shared types and constants for the interval admission block
// Table sizes, time width, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package idba_pkg;

    localparam int SINGLE_ENTRIES = 1024;
    localparam int DOUBLE_ENTRIES = 1024;
    localparam int TIME_BITS      = 30;

    // index and fill-count widths of the two tables
    localparam int S_IW  = $clog2(SINGLE_ENTRIES);
    localparam int S_CW  = $clog2(SINGLE_ENTRIES + 1);
    localparam int D_IW  = $clog2(DOUBLE_ENTRIES);
    localparam int D_CW  = $clog2(DOUBLE_ENTRIES + 1);
    localparam int IDX_W = (S_CW > D_CW) ? S_CW : D_CW;
    localparam int SUM_W = IDX_W + 1;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        t_time lo;
        t_time hi;
    } t_span;

    typedef enum logic [1:0] {
        ST_ADMIT  = 2'd0,
        ST_TRIPLE = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_DSCAN,
        S_SCNT,
        S_SWR,
        S_SFIN
    } t_state;

endpackage

### rtl/core/idba_olap_unit.sv
// ----------------------------------------------------------------------------
// idba_olap_unit - shared overlap test and clip
// Tests a stored span against the request and gives their intersection.
// ----------------------------------------------------------------------------
module idba_olap_unit (
    input  idba_pkg::t_span i_entry,
    input  idba_pkg::t_span i_req,
    output logic            o_hit,
    output idba_pkg::t_span o_clip
);
    import idba_pkg::*;

    // half-open spans overlap when each starts before the other ends
    assign o_hit     = (i_entry.lo < i_req.hi) && (i_req.lo < i_entry.hi);
    assign o_clip.lo = (i_entry.lo > i_req.lo) ? i_entry.lo : i_req.lo;
    assign o_clip.hi = (i_entry.hi < i_req.hi) ? i_entry.hi : i_req.hi;

endmodule

### rtl/core/interval_double_booking_admission.sv
// ----------------------------------------------------------------------------
// interval_double_booking_admission - admit reservations, no triple cover
// Keeps admitted and doubly covered spans; refuses triple cover or overflow.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. The block then
// walks its tables with a single overlap/clip unit, one stored entry per
// cycle through a registered memory read: first the double table (stops at
// the first hit with status 1), then the admitted table twice - once to count
// overlaps for the room check, once to append the clipped overlaps to the
// double table. An empty request (start >= end) is admitted with no table
// scan. busy stays high throughout. The status beat is shown on o_status for
// exactly one cycle with o_valid; the receiver cannot stall it, so it must
// take every beat.
// Status: 0 admitted, 1 refused (triple overlap, takes priority), 2 refused
// (table full, nothing written). Table contents need no clearing after reset:
// only entries below the fill counts are ever used.
module interval_double_booking_admission (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  idba_pkg::t_time          i_start_time,
    input  idba_pkg::t_time          i_end_time,
    output logic                     o_valid,
    output logic [1:0]               o_status
);
    import idba_pkg::*;

    t_state r_state, n_state;
    t_span  r_req,   n_req;
    logic [IDX_W-1:0] r_idx,  n_idx;
    logic             r_pv,   n_pv;     // read data valid this cycle
    logic [S_CW-1:0]  r_scnt, n_scnt;
    logic [D_CW-1:0]  r_dcnt, n_dcnt;
    logic [S_CW-1:0]  r_hits, n_hits;
    logic             r_valid, n_valid;
    t_status          r_status, n_status;

    // tables
    t_span s_mem [SINGLE_ENTRIES];
    t_span d_mem [DOUBLE_ENTRIES];
    t_span r_s_rdata, r_d_rdata;
    logic  s_we, d_we;

    t_span entry, clip;
    logic  hit;
    logic [IDX_W-1:0] limit;
    logic  issue;

    always_ff @(posedge i_clk) begin
        r_s_rdata <= s_mem[r_idx[S_IW-1:0]];
        r_d_rdata <= d_mem[r_idx[D_IW-1:0]];
        if (s_we) begin
            s_mem[r_scnt[S_IW-1:0]] <= r_req;
        end
        if (d_we) begin
            d_mem[r_dcnt[D_IW-1:0]] <= clip;
        end
    end

    // one compare/clip unit serves every pass
    assign entry = (r_state == S_DSCAN) ? r_d_rdata : r_s_rdata;

    idba_olap_unit u_olap (
        .i_entry (entry),
        .i_req   (r_req),
        .o_hit   (hit),
        .o_clip  (clip)
    );

    assign limit = (r_state == S_DSCAN) ? IDX_W'(r_dcnt) : IDX_W'(r_scnt);
    assign issue = (r_idx != limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pv    <= 1'b0;
            r_scnt  <= '0;
            r_dcnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= n_pv;
            r_scnt  <= n_scnt;
            r_dcnt  <= n_dcnt;
            r_valid <= n_valid;
        end
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_hits   <= n_hits;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_idx    = r_idx;
        n_pv     = 1'b0;
        n_scnt   = r_scnt;
        n_dcnt   = r_dcnt;
        n_hits   = r_hits;
        n_valid  = 1'b0;
        n_status = r_status;
        s_we     = 1'b0;
        d_we     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req.lo = i_start_time;
                    n_req.hi = i_end_time;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                n_idx = '0;
                if (r_req.lo >= r_req.hi) begin
                    // empty span: admitted, nothing stored
                    n_valid  = 1'b1;
                    n_status = ST_ADMIT;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_DSCAN;
                end
            end
            S_DSCAN: begin
                if (r_pv && hit) begin
                    n_valid  = 1'b1;
                    n_status = ST_TRIPLE;
                    n_state  = S_IDLE;
                end else if (issue) begin
                    n_pv  = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_pv) begin
                    n_idx   = '0;
                    n_hits  = '0;
                    n_state = S_SCNT;
                end
            end
            S_SCNT: begin
                if (r_pv && hit) begin
                    n_hits = r_hits + 1'b1;
                end
                if (issue) begin
                    n_pv  = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_pv) begin
                    n_idx = '0;
                    if ((r_scnt == S_CW'(SINGLE_ENTRIES)) ||
                        (SUM_W'(r_dcnt) + SUM_W'(r_hits) > SUM_W'(DOUBLE_ENTRIES))) begin
                        n_valid  = 1'b1;
                        n_status = ST_FULL;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_SWR;
                    end
                end
            end
            S_SWR: begin
                if (r_pv && hit) begin
                    d_we   = 1'b1;
                    n_dcnt = r_dcnt + 1'b1;
                end
                if (issue) begin
                    n_pv  = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_pv) begin
                    n_state = S_SFIN;
                end
            end
            S_SFIN: begin
                s_we     = 1'b1;
                n_scnt   = r_scnt + 1'b1;
                n_valid  = 1'b1;
                n_status = ST_ADMIT;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

    // ---- assertions ----
    // a status beat always lands as the sequencer returns to idle
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE))
        else $error("status beat while busy");

    // an accepted request always makes the block busy next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but not busy");

    // fill counts never pass table depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scnt <= S_CW'(SINGLE_ENTRIES)) && (r_dcnt <= D_CW'(DOUBLE_ENTRIES)))
        else $error("table fill count overrun");

    // no double-table write outside the append pass
    a_dwr_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_we |-> (r_state == S_SWR) && (r_dcnt < D_CW'(DOUBLE_ENTRIES)))
        else $error("double table write out of pass");

endmodule
